### rtl/cube_map_texel_select_core_assert.svh
// Assertion macros shared by the cube-map texel select RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef CUBE_MAP_TEXEL_SELECT_CORE_ASSERT_SVH
`define CUBE_MAP_TEXEL_SELECT_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clock, resetn, pre, post) \
  label: assert property (@(posedge clock) disable iff (!resetn) (pre) |-> (post)) \
    else $error("assertion failed: implication does not hold");
`define ASSERT_NEVER(label, clock, resetn, cond) \
  label: assert property (@(posedge clock) disable iff (!resetn) !(cond)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_IMPLIES(label, clock, resetn, pre, post)
`define ASSERT_NEVER(label, clock, resetn, cond)
`endif
`endif

### rtl/ctms_pkg.sv
// Types, widths and constants for the cube-map texel select pipeline.
// Depends on nothing; used by every module of the block.
package ctms_pkg;

  localparam int MAX_FACE_SIZE = 4096;
  localparam int QW = $clog2(MAX_FACE_SIZE);
  localparam int DIR_W = 16;
  localparam int MAG_W = DIR_W;
  localparam int SUM_W = DIR_W + 1;
  localparam int DEN_W = MAG_W + 1;
  localparam int NUM_W = SUM_W + QW - 1 + 1;
  localparam int CFG_W = 13;
  localparam int TEX_W = 12;

  localparam logic [CFG_W-1:0] FACE_SIZE_MIN = CFG_W'(4);
  localparam logic [CFG_W-1:0] FACE_SIZE_MAX = CFG_W'(MAX_FACE_SIZE);
  localparam logic [CFG_W-1:0] FACE_SIZE_RESET = CFG_W'(256);

  typedef enum logic [2:0] {
    FACE_PX,
    FACE_NX,
    FACE_PY,
    FACE_NY,
    FACE_PZ,
    FACE_NZ
  } face_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } in_req_t;

  typedef struct packed {
    face_t            face;
    logic [TEX_W-1:0] texel_col;
    logic [TEX_W-1:0] texel_row;
  } out_res_t;

  typedef struct packed {
    face_t            face;
    logic [SUM_W-1:0] sum_u;
    logic [SUM_W-1:0] sum_v;
    logic [MAG_W-1:0] mag;
  } sel_t;

  typedef struct packed {
    face_t            face;
    logic [NUM_W-1:0] num_u;
    logic [NUM_W-1:0] num_v;
    logic [DEN_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    face_t            face;
    logic [NUM_W-1:0] rem_u;
    logic [NUM_W-1:0] rem_v;
    logic [DEN_W-1:0] den;
    logic [QW-1:0]    q_u;
    logic [QW-1:0]    q_v;
  } div_stage_t;

endpackage

### rtl/ctms_select.sv
// Stage 1: major axis and face pick, offset numerators n+m and magnitude m.
// Depends on ctms_pkg and cube_map_texel_select_core_assert.svh.
`include "cube_map_texel_select_core_assert.svh"
module ctms_select (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  ctms_pkg::in_req_t in_req,
  output logic              sel_vld,
  output ctms_pkg::sel_t    sel
);
  import ctms_pkg::*;

  logic [DIR_W-1:0] x_u, y_u, z_u;
  logic [MAG_W-1:0] ax, ay, az;
  logic signed [SUM_W:0] x_e, y_e, z_e, nu, nv, su, sv;
  logic              sel_vld_r;
  sel_t              sel_r, sel_nxt;
  logic [DEN_W-1:0]  twice_mag;

  assign x_u = in_req.dir_x;
  assign y_u = in_req.dir_y;
  assign z_u = in_req.dir_z;
  assign ax = x_u[DIR_W-1] ? (~x_u + MAG_W'(1)) : x_u;
  assign ay = y_u[DIR_W-1] ? (~y_u + MAG_W'(1)) : y_u;
  assign az = z_u[DIR_W-1] ? (~z_u + MAG_W'(1)) : z_u;
  assign x_e = (SUM_W+1)'(in_req.dir_x);
  assign y_e = (SUM_W+1)'(in_req.dir_y);
  assign z_e = (SUM_W+1)'(in_req.dir_z);

  always_comb begin
    sel_nxt = '0;
    nu = '0;
    nv = '0;
    if (ax >= ay && ax >= az) begin
      sel_nxt.mag = ax;
      if (!x_u[DIR_W-1]) begin
        sel_nxt.face = FACE_PX;
        nu = -z_e;
        nv = y_e;
      end else begin
        sel_nxt.face = FACE_NX;
        nu = z_e;
        nv = y_e;
      end
    end else if (ay >= az) begin
      sel_nxt.mag = ay;
      if (!y_u[DIR_W-1]) begin
        sel_nxt.face = FACE_PY;
        nu = x_e;
        nv = -z_e;
      end else begin
        sel_nxt.face = FACE_NY;
        nu = x_e;
        nv = z_e;
      end
    end else begin
      sel_nxt.mag = az;
      if (!z_u[DIR_W-1]) begin
        sel_nxt.face = FACE_PZ;
        nu = x_e;
        nv = y_e;
      end else begin
        sel_nxt.face = FACE_NZ;
        nu = -x_e;
        nv = y_e;
      end
    end
    if (sel_nxt.mag == '0) begin
      sel_nxt.face = FACE_PX;
      sel_nxt.mag = MAG_W'(1);
      nu = '0;
      nv = '0;
    end
    su = nu + (SUM_W+1)'(sel_nxt.mag);
    sv = nv + (SUM_W+1)'(sel_nxt.mag);
    sel_nxt.sum_u = su[SUM_W-1:0];
    sel_nxt.sum_v = sv[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
    end else begin
      sel_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
  end

  assign sel_vld = sel_vld_r;
  assign sel = sel_r;
  assign twice_mag = {sel_r.mag, 1'b0};

  `ASSERT_NEVER(a_mag_nonzero, clk, rst_n, sel_vld_r && sel_r.mag == '0)
  `ASSERT_IMPLIES(a_sum_u_range, clk, rst_n, sel_vld_r, sel_r.sum_u <= twice_mag)
  `ASSERT_IMPLIES(a_sum_v_range, clk, rst_n, sel_vld_r, sel_r.sum_v <= twice_mag)

endmodule

### rtl/ctms_scale.sv
// Stage 2: numerators (n+m)*(S-1)+m and divisor 2m for both texel axes.
// Depends on ctms_pkg.
module ctms_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ctms_pkg::CFG_W-1:0]    face_size,
  input  logic                          sel_vld,
  input  ctms_pkg::sel_t                sel,
  output logic                          scl_vld,
  output ctms_pkg::div_in_t             scl
);
  import ctms_pkg::*;

  logic [CFG_W-1:0]     eff;
  logic [QW-1:0]        sm1;
  logic [NUM_W:0]       prod_u, prod_v;
  logic                 scl_vld_r;
  div_in_t              scl_r, scl_nxt;

  assign eff = (face_size < FACE_SIZE_MIN) ? FACE_SIZE_MIN :
               (face_size > FACE_SIZE_MAX) ? FACE_SIZE_MAX : face_size;
  assign sm1 = QW'(eff - CFG_W'(1));
  assign prod_u = (NUM_W+1)'(sel.sum_u) * (NUM_W+1)'(sm1);
  assign prod_v = (NUM_W+1)'(sel.sum_v) * (NUM_W+1)'(sm1);

  always_comb begin
    scl_nxt.face = sel.face;
    scl_nxt.num_u = prod_u[NUM_W-1:0] + NUM_W'(sel.mag);
    scl_nxt.num_v = prod_v[NUM_W-1:0] + NUM_W'(sel.mag);
    scl_nxt.den = {sel.mag, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_vld_r <= 1'b0;
    end else begin
      scl_vld_r <= sel_vld;
    end
  end

  always_ff @(posedge clk) begin
    scl_r <= scl_nxt;
  end

  assign scl_vld = scl_vld_r;
  assign scl = scl_r;

endmodule

### rtl/ctms_div.sv
// Stages 3 on: restoring divider, one quotient bit per stage, two lanes.
// Depends on ctms_pkg and cube_map_texel_select_core_assert.svh.
`include "cube_map_texel_select_core_assert.svh"
module ctms_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  div_vld,
  input  ctms_pkg::div_in_t     div_in,
  output logic                  res_vld,
  output ctms_pkg::div_stage_t  res
);
  import ctms_pkg::*;

  logic       stg_vld_r [QW];
  div_stage_t stg_r     [QW];
  logic [NUM_W:0] in_bound;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int BIT = QW - 1 - k;
    logic            cur_vld;
    div_stage_t      cur, stg_nxt;
    logic [NUM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign cur_vld = div_vld;
      assign cur = '{face: div_in.face, rem_u: div_in.num_u, rem_v: div_in.num_v,
                     den: div_in.den, q_u: '0, q_v: '0};
    end else begin : g_next
      assign cur_vld = stg_vld_r[k-1];
      assign cur = stg_r[k-1];
    end

    assign trial = NUM_W'(cur.den) << BIT;

    always_comb begin
      stg_nxt = cur;
      if (cur.rem_u >= trial) begin
        stg_nxt.rem_u = cur.rem_u - trial;
        stg_nxt.q_u[BIT] = 1'b1;
      end
      if (cur.rem_v >= trial) begin
        stg_nxt.rem_v = cur.rem_v - trial;
        stg_nxt.q_v[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_vld_r[k] <= 1'b0;
      end else begin
        stg_vld_r[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      stg_r[k] <= stg_nxt;
    end
  end

  assign res_vld = stg_vld_r[QW-1];
  assign res = stg_r[QW-1];
  assign in_bound = (NUM_W+1)'(div_in.den) << QW;

  `ASSERT_IMPLIES(a_in_bound, clk, rst_n, div_vld, (NUM_W+1)'(div_in.num_u) < in_bound)
  `ASSERT_IMPLIES(a_rem_u, clk, rst_n, res_vld, res.rem_u < NUM_W'(res.den))
  `ASSERT_IMPLIES(a_rem_v, clk, rst_n, res_vld, res.rem_v < NUM_W'(res.den))

endmodule

### rtl/cube_map_texel_select_core.sv
// Cube-map face and texel select: top level with face size register.
// Depends on ctms_pkg, ctms_select, ctms_scale and ctms_div.
//
// Usage:
//   Request channel: drive in_req (dir_x, dir_y, dir_z, signed Q1.15) and
//   raise start; the request is taken at any rising edge with start high,
//   since busy is always low. One request may enter every cycle.
//   Result channel: out_strobe is high for one cycle with out_res holding
//   face, texel_col and texel_row. Results leave in request order, one per
//   request, after face select, numerator scaling (a 17x12 multiply per
//   axis) and a pipelined restoring divider that resolves one quotient bit
//   per stage.
//   Throughput is one request per cycle.
//   The receiver cannot stall; every result must be taken when strobed.
//   Configuration: cfg_we with cfg_wdata writes face_size; write it only
//   while no request is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and sets face_size
//   to 256. No result is strobed until requests arrive after reset.
module cube_map_texel_select_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  ctms_pkg::in_req_t           in_req,
  output logic                        out_strobe,
  output ctms_pkg::out_res_t          out_res,
  input  logic                        cfg_we,
  input  logic [ctms_pkg::CFG_W-1:0]  cfg_wdata
);
  import ctms_pkg::*;

  logic [CFG_W-1:0] face_size_r;
  logic             in_vld;
  logic             sel_vld, scl_vld, res_vld;
  sel_t             sel;
  div_in_t          scl;
  div_stage_t       res;

  assign busy = 1'b0;
  assign in_vld = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_size_r <= FACE_SIZE_RESET;
    end else if (cfg_we) begin
      face_size_r <= cfg_wdata;
    end
  end

  ctms_select u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_req  (in_req),
    .sel_vld (sel_vld),
    .sel     (sel)
  );

  ctms_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .face_size (face_size_r),
    .sel_vld   (sel_vld),
    .sel       (sel),
    .scl_vld   (scl_vld),
    .scl       (scl)
  );

  ctms_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_vld (scl_vld),
    .div_in  (scl),
    .res_vld (res_vld),
    .res     (res)
  );

  assign out_strobe = res_vld;
  assign out_res.face = res.face;
  assign out_res.texel_col = TEX_W'(res.q_u);
  assign out_res.texel_row = TEX_W'(res.q_v);

endmodule
